### hdl/counted_step_pulse_generator_top_macros.svh
// Assertion macros for the step pulse generator RTL.
`ifndef COUNTED_STEP_PULSE_GENERATOR_TOP_MACROS_SVH
`define COUNTED_STEP_PULSE_GENERATOR_TOP_MACROS_SVH
`ifndef SYNTH
`define CSPG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cspg same-cycle check failed");
`define CSPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cspg next-cycle check failed");
`else
`define CSPG_ASSERT_SAME(label, clk, rst, ante, cons)
`define CSPG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hdl/cspg_pkg.sv
// Types and constants for the counted step pulse generator.
package cspg_pkg;

   localparam int MAX_CHANNELS = 2;
   localparam int TOTAL_BITS = 8;
   localparam int CSR_DATA_BITS = 2;

   typedef enum logic {
      CMD_TICK = 1'b0,
      CMD_ARM  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_CLOCK_IDLE     = 2'd0,
      CSR_FORWARD        = 2'd1,
      CSR_ENABLE_ACTIVE  = 2'd2,
      CSR_ENABLE_PRESENT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                  cmd;
      logic                  channel;
      logic                  direction;
      logic [TOTAL_BITS-1:0] pulse_total;
      logic                  run_enable;
   } req_type;

   typedef struct packed {
      logic step_out_0;
      logic step_out_1;
      logic dir_out_0;
      logic dir_out_1;
      logic enable_out_0;
      logic enable_out_1;
      logic done_0;
      logic done_1;
   } rsp_type;

endpackage

### hdl/counted_step_pulse_generator_top.sv
// Two-channel counted step/direction pulse generator, top level.
//
//   port group | dir | handshake          | payload
//   req_       | in  | req_valid/req_stall | cspg_pkg::req_type
//   rsp_       | out | rsp_valid/rsp_stall | cspg_pkg::rsp_type
//   csr_       | in  | csr_valid/csr_ready | csr_index, csr_data
//
// One item per cycle while req_stall is low; each transfer updates all channel
// state and its result appears in the output register on the next cycle.
// The output register is the only buffer: req_stall is high while it holds a
// result that rsp_stall keeps from leaving.
// Synchronous active-high reset initialises channel state, pins and csr registers (the
// output data register is not reset); no clearing pass. csr writes are always ready.
`include "counted_step_pulse_generator_top_macros.svh"

module counted_step_pulse_generator_top #(
   parameter int CHANNELS   = 2,
   parameter int COUNT_BITS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  cspg_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output cspg_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  cspg_pkg::csr_index_type                csr_index,
   input  logic [cspg_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import cspg_pkg::*;

   logic                  clock_idle_ff;
   logic                  forward_ff;
   logic                  enable_active_ff;
   logic [MAX_CHANNELS-1:0] enable_present_ff;

   logic [MAX_CHANNELS-1:0] armed_ff, armed_in;
   logic [MAX_CHANNELS-1:0] phase_ff, phase_in;
   logic [MAX_CHANNELS-1:0] step_ff, step_in;
   logic [MAX_CHANNELS-1:0] dir_ff, dir_in;
   logic [MAX_CHANNELS-1:0] enable_ff, enable_in;
   logic [MAX_CHANNELS-1:0] done_in;
   logic [COUNT_BITS-1:0]   target_ff [MAX_CHANNELS];
   logic [COUNT_BITS-1:0]   target_in [MAX_CHANNELS];
   logic [COUNT_BITS-1:0]   count_ff  [MAX_CHANNELS];
   logic [COUNT_BITS-1:0]   count_in  [MAX_CHANNELS];

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    req_accept;
   logic    csr_write;
   logic    arm_accept;
   logic    rsp_done_any;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid & csr_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign arm_accept   = req_accept & (req_data.cmd == CMD_ARM);
   assign rsp_done_any = rsp_data_ff.done_0 | rsp_data_ff.done_1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_idle_ff     <= 1'b1;
         forward_ff        <= 1'b0;
         enable_active_ff  <= 1'b0;
         enable_present_ff <= '1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CLOCK_IDLE:     clock_idle_ff     <= csr_data[0];
            CSR_FORWARD:        forward_ff        <= csr_data[0];
            CSR_ENABLE_ACTIVE:  enable_active_ff  <= csr_data[0];
            CSR_ENABLE_PRESENT: enable_present_ff <= csr_data[MAX_CHANNELS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      armed_in  = armed_ff;
      phase_in  = phase_ff;
      step_in   = step_ff;
      dir_in    = dir_ff;
      enable_in = enable_ff;
      done_in   = '0;
      target_in = target_ff;
      count_in  = count_ff;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
         if (c < CHANNELS) begin
            if (req_data.cmd == CMD_ARM) begin
               if (req_data.channel == 1'(c)) begin
                  armed_in[c]  = req_data.run_enable;
                  phase_in[c]  = clock_idle_ff;
                  target_in[c] = COUNT_BITS'(req_data.pulse_total);
                  count_in[c]  = '0;
                  if (req_data.run_enable) begin
                     dir_in[c] = forward_ff ^ req_data.direction;
                     if (enable_present_ff[c]) begin
                        enable_in[c] = enable_active_ff;
                     end
                  end else if (enable_present_ff[c]) begin
                     enable_in[c] = ~enable_active_ff;
                  end
               end
            end else if (armed_ff[c]) begin
               if ((target_ff[c] != '0) && (count_ff[c] >= target_ff[c])) begin
                  done_in[c] = 1'b1;
               end else begin
                  step_in[c]  = phase_ff[c];
                  phase_in[c] = ~phase_ff[c];
                  if (!phase_ff[c]) begin
                     count_in[c] = count_ff[c] + COUNT_BITS'(1);
                  end
               end
            end
         end
      end
      rsp_data_in.step_out_0   = step_in[0];
      rsp_data_in.step_out_1   = step_in[1];
      rsp_data_in.dir_out_0    = dir_in[0];
      rsp_data_in.dir_out_1    = dir_in[1];
      rsp_data_in.enable_out_0 = enable_in[0];
      rsp_data_in.enable_out_1 = enable_in[1];
      rsp_data_in.done_0       = done_in[0];
      rsp_data_in.done_1       = done_in[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff  <= '0;
         phase_ff  <= '1;
         step_ff   <= '1;
         dir_ff    <= '1;
         enable_ff <= '1;
         for (int c = 0; c < MAX_CHANNELS; c++) begin
            target_ff[c] <= '0;
            count_ff[c]  <= '0;
         end
      end else if (req_accept) begin
         armed_ff  <= armed_in;
         phase_ff  <= phase_in;
         step_ff   <= step_in;
         dir_ff    <= dir_in;
         enable_ff <= enable_in;
         target_ff <= target_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `CSPG_ASSERT_SAME(a_stall_only_when_full, clock, reset, req_stall, rsp_valid_ff)
   `CSPG_ASSERT_NEXT(a_transfer_gives_result, clock, reset, req_accept, rsp_valid_ff)
   `CSPG_ASSERT_NEXT(a_arm_no_done, clock, reset, arm_accept, !rsp_done_any)
   `CSPG_ASSERT_SAME(a_count_in_range, clock, reset, target_ff[0] != '0, count_ff[0] <= target_ff[0])

endmodule
